### rtl/ult_pkg.sv
package ult_pkg;

  localparam int LABEL_W = 32;

  typedef enum logic [2:0] {
    FUNC_ADD    = 3'd0,
    FUNC_REMOVE = 3'd1,
    FUNC_FIND   = 3'd2,
    FUNC_READ   = 3'd3,
    FUNC_SET    = 3'd4,
    FUNC_CLEAR  = 3'd5,
    FUNC_INIT   = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [2:0]                func;
    logic signed [LABEL_W-1:0] label;
    logic [7:0]                index;
  } req_t;

  typedef struct packed {
    logic                      ok;
    logic [3:0]                found_index;
    logic signed [LABEL_W-1:0] label_out;
    logic [4:0]                count;
  } rsp_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic               cmp;
    logic               add;
    logic               rem;
    logic               set;
    logic               init;
    logic [LABEL_W-1:0] key;
  } cell_cmd_t;

endpackage

### rtl/ult_cell.sv
module ult_cell
  import ult_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int POS   = 0
) (
  input  logic                       clk,
  input  cell_cmd_t                  cmd,
  input  logic [$clog2(DEPTH+1)-1:0] count,
  input  logic [7:0]                 index,
  input  logic [$clog2(DEPTH)-1:0]   pos,
  input  logic [$clog2(DEPTH+1)-1:0] init_n,
  input  logic [LABEL_W-1:0]         next_label,
  output logic [LABEL_W-1:0]         label,
  output logic                       match,
  output logic [$clog2(DEPTH)-1:0]   pos_term,
  output logic [LABEL_W-1:0]         rd_term
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  logic live;
  logic at_index;

  assign live     = CW'(POS) < count;
  assign at_index = index == 8'(POS);

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      match <= live && (label == cmd.key);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.add && (CW'(POS) == count)) begin
      label <= cmd.key;
    end else if (cmd.rem && (IW'(POS) >= pos)) begin
      label <= next_label;          // close the gap from the right neighbor
    end else if (cmd.set && at_index) begin
      label <= cmd.key;
    end else if (cmd.init && (CW'(POS) < init_n)) begin
      label <= LABEL_W'(POS);
    end
  end

  assign pos_term = match ? IW'(POS) : '0;
  assign rd_term  = at_index ? label : '0;

endmodule

### rtl/unique_label_table.sv
// An accepted request beat passes through the compare state and then the
// execute state of the cell row; its response beat is registered in the execute
// state once the output register is free. The next request is taken in that
// execute cycle, as the response is registered, and not before.
// Reset clears the fill count, initial_count and both handshakes; label cells
// are not cleared and only entries below the count are ever read.
module unique_label_table
  import ult_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output rsp_t       rsp,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata
);

  localparam int IW = $clog2(DEPTH);       // position width
  localparam int CW = $clog2(DEPTH+1);     // count width, holds DEPTH itself
  localparam int WW = CW + 8;              // common width for range compares

  state_t state, state_next;
  req_t   op;                              // request under work
  logic [CW-1:0] cnt, cnt_next;
  logic [4:0]    init_cnt;                 // initial_count register

  logic rsp_free;
  logic cmp_en;
  logic exec_en;

  // cell row
  logic [LABEL_W-1:0] cell_label [DEPTH];
  logic [LABEL_W-1:0] cell_next  [DEPTH];
  logic               cell_match [DEPTH];
  logic [IW-1:0]      cell_pos   [DEPTH];
  logic [LABEL_W-1:0] cell_rd    [DEPTH];
  cell_cmd_t          cmd;

  // reductions over the row; labels are unique so at most one cell matches
  logic               hit;
  logic [IW-1:0]      hit_pos;
  logic [LABEL_W-1:0] rd_label;

  logic          idx_ok;
  logic          add_ok;
  logic [CW-1:0] init_n;
  logic          ok;
  rsp_t          rsp_d;

  assign rsp_free = !rsp_valid || rsp_ready;

  // ---------------- control FSM ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_CMP;
      end
      ST_CMP: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (rsp_free) state_next = req_valid ? ST_CMP : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_ready = 1'b0;
    cmp_en    = 1'b0;
    exec_en   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
      end
      ST_CMP: begin
        cmp_en = 1'b1;
      end
      ST_EXEC: begin
        // finish this beat and take the next one in the same cycle
        exec_en   = rsp_free;
        req_ready = rsp_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      op <= req;
    end
  end

  // ---------------- config ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      init_cnt <= '0;
    end else if (cfg_we) begin
      init_cnt <= cfg_wdata;
    end
  end

  // ---------------- row reduction ----------------
  always_comb begin
    hit      = 1'b0;
    hit_pos  = '0;
    rd_label = '0;
    for (int i = 0; i < DEPTH; i++) begin
      hit      = hit | cell_match[i];
      hit_pos  = hit_pos | cell_pos[i];
      rd_label = rd_label | cell_rd[i];
    end
  end

  // ---------------- execute decode ----------------
  assign idx_ok = WW'(op.index) < WW'(cnt);
  assign add_ok = !hit && (WW'(cnt) < WW'(DEPTH));
  // init loads min(initial_count, DEPTH) labels
  assign init_n = (WW'(init_cnt) > WW'(DEPTH)) ? CW'(DEPTH) : CW'(init_cnt);

  always_comb begin
    ok       = 1'b0;
    cnt_next = cnt;
    rsp_d    = '0;
    unique case (op.func)
      FUNC_ADD: begin
        ok = add_ok;
        if (add_ok) cnt_next = cnt + CW'(1);
      end
      FUNC_REMOVE: begin
        ok = hit;
        if (hit) cnt_next = cnt - CW'(1);
      end
      FUNC_FIND: begin
        ok = hit;
        if (hit) rsp_d.found_index = 4'(hit_pos);
      end
      FUNC_READ: begin
        ok = idx_ok;
        if (idx_ok) rsp_d.label_out = rd_label;
      end
      FUNC_SET: begin
        ok = idx_ok && !hit;
      end
      FUNC_CLEAR: begin
        ok       = 1'b1;
        cnt_next = '0;
      end
      FUNC_INIT: begin
        ok       = 1'b1;
        cnt_next = init_n;
      end
      default: begin
        // unused code: no change, count still reported
      end
    endcase
    rsp_d.ok    = ok;
    rsp_d.count = 5'(cnt_next);
  end

  always_comb begin
    cmd      = '0;
    cmd.key  = op.label;
    cmd.cmp  = cmp_en;
    cmd.add  = exec_en && ok && (op.func == FUNC_ADD);
    cmd.rem  = exec_en && ok && (op.func == FUNC_REMOVE);
    cmd.set  = exec_en && ok && (op.func == FUNC_SET);
    cmd.init = exec_en && (op.func == FUNC_INIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (exec_en) begin
      cnt <= cnt_next;
    end
  end

  // ---------------- response register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (exec_en) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_en) begin
      rsp <= rsp_d;
    end
  end

  // ---------------- cells ----------------
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == DEPTH - 1) begin : g_last
      assign cell_next[g] = cell_label[g];
    end else begin : g_mid
      assign cell_next[g] = cell_label[g+1];
    end

    ult_cell #(
      .DEPTH (DEPTH),
      .POS   (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (cnt),
      .index      (op.index),
      .pos        (hit_pos),
      .init_n     (init_n),
      .next_label (cell_next[g]),
      .label      (cell_label[g]),
      .match      (cell_match[g]),
      .pos_term   (cell_pos[g]),
      .rd_term    (cell_rd[g])
    );
  end

endmodule

### sim/unique_label_table_tb.sv
module unique_label_table_tb
  import ult_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TABLE_DEPTH = 16;
  // func code 7 has no operation behind it
  localparam logic [2:0]  FUNC_UNUSED = 3'd7;
  localparam logic signed [LABEL_W-1:0] LABEL_MIN = 32'sh8000_0000;
  localparam logic signed [LABEL_W-1:0] LABEL_MAX = 32'sh7fff_ffff;

  logic       clk;
  logic       rst;
  logic       req_valid;
  logic       req_ready;
  req_t       req;
  logic       rsp_valid;
  logic       rsp_ready;
  rsp_t       rsp;
  logic       cfg_we;
  logic [4:0] cfg_wdata;

  // shadow copy of the table, kept in step with every accepted request beat
  logic signed [LABEL_W-1:0] shadow_labels [TABLE_DEPTH];
  int                        shadow_fill;
  logic [4:0]                shadow_init_count;

  rsp_t expected_rsp[$];

  // idle bursts on each side; both off for the closing stretch
  bit req_gaps;
  bit rsp_gaps;

  int errors;
  int beats_sent;
  int beats_checked;
  int full_refusals;
  int cfg_writes;

  unique_label_table #(.DEPTH(TABLE_DEPTH)) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: slowest legal run is well under a millisecond
  initial begin
    #5_000_000;
    $display("unique_label_table regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Table predictor
  // ---------------------------------------------------------------------------

  // position among filled entries, TABLE_DEPTH when absent
  function automatic int label_position(logic signed [LABEL_W-1:0] lab);
    for (int i = 0; i < shadow_fill; i++)
      if (shadow_labels[i] == lab) return i;
    return TABLE_DEPTH;
  endfunction

  function automatic rsp_t apply_table_op(req_t r);
    rsp_t res;
    int   pos;
    int   n;
    res = '0;
    pos = label_position(r.label);
    case (r.func)
      FUNC_ADD: begin
        if (shadow_fill >= TABLE_DEPTH) full_refusals++;
        if (pos == TABLE_DEPTH && shadow_fill < TABLE_DEPTH) begin
          shadow_labels[shadow_fill] = r.label;
          shadow_fill++;
          res.ok = 1'b1;
        end
      end
      FUNC_REMOVE: begin
        if (pos < TABLE_DEPTH) begin
          // later entries close the gap
          for (int i = pos; i + 1 < shadow_fill; i++)
            shadow_labels[i] = shadow_labels[i + 1];
          shadow_fill--;
          res.ok = 1'b1;
        end
      end
      FUNC_FIND: begin
        if (pos < TABLE_DEPTH) begin
          res.ok          = 1'b1;
          res.found_index = pos[3:0];
        end
      end
      FUNC_READ: begin
        if (int'(r.index) < shadow_fill) begin
          res.ok        = 1'b1;
          res.label_out = shadow_labels[r.index];
        end
      end
      FUNC_SET: begin
        // refused when the label is anywhere in the table, even at the target
        if (int'(r.index) < shadow_fill && pos == TABLE_DEPTH) begin
          shadow_labels[r.index] = r.label;
          res.ok = 1'b1;
        end
      end
      FUNC_CLEAR: begin
        shadow_fill = 0;
        res.ok      = 1'b1;
      end
      FUNC_INIT: begin
        n = (shadow_init_count < TABLE_DEPTH) ? shadow_init_count : TABLE_DEPTH;
        for (int i = 0; i < n; i++)
          shadow_labels[i] = i;
        shadow_fill = n;
        res.ok      = 1'b1;
      end
      default: ;
    endcase
    res.count = shadow_fill[4:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Response side: random backpressure and the checker
  // ---------------------------------------------------------------------------

  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_gaps && $urandom_range(0, 4) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      beats_checked++;
      if (expected_rsp.size() == 0) begin
        $error("response beat with nothing expected: ok=%0d idx=%0d label=%0d count=%0d",
               rsp.ok, rsp.found_index, rsp.label_out, rsp.count);
        errors++;
      end else begin
        want = expected_rsp.pop_front();
        if (rsp.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, rsp.ok);
          errors++;
        end
        if (rsp.found_index !== want.found_index) begin
          $error("found_index: expected %0d, got %0d", want.found_index, rsp.found_index);
          errors++;
        end
        if (rsp.label_out !== want.label_out) begin
          $error("label_out: expected %0d, got %0d", want.label_out, rsp.label_out);
          errors++;
        end
        if (rsp.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, rsp.count);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side helpers
  // ---------------------------------------------------------------------------

  function automatic req_t make_req(logic [2:0] f, logic signed [LABEL_W-1:0] lab,
                                    logic [7:0] idx);
    req_t r;
    r.func  = f;
    r.label = lab;
    r.index = idx;
    return r;
  endfunction

  // called at a rising edge; returns once the beat is taken, valid high but for a gap
  task automatic send_beat(input req_t r);
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    expected_rsp = {expected_rsp, apply_table_op(r)};
    beats_sent++;
    if (req_gaps && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // drop valid and let every outstanding response drain
  task automatic drain_table;
    int guard;
    req_valid <= 1'b0;
    guard = 0;
    while (expected_rsp.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    // every request yields a response; the extra wait after the queue empties covers the pipe
    repeat (4) @(posedge clk);
  endtask

  task automatic write_init_count(input logic [4:0] v);
    drain_table();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we            <= 1'b0;
    shadow_init_count  = v;
    cfg_writes++;
  endtask

  // most labels come from a small pool so adds collide and finds hit
  function automatic logic signed [LABEL_W-1:0] pick_label;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $signed($urandom_range(0, 23)) - 4;
    if (sel < 80) begin
      case ($urandom_range(0, 3))
        0: return LABEL_MIN;
        1: return LABEL_MAX;
        2: return -1;
        default: return 0;
      endcase
    end
    return $signed($urandom);
  endfunction

  function automatic logic [7:0] pick_index;
    if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 17));
    return 8'($urandom_range(0, 255));
  endfunction

  // add-heavy mix keeps the table well populated; clear stays rare
  function automatic logic [2:0] pick_func;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 30) return FUNC_ADD;
    if (sel < 45) return FUNC_REMOVE;
    if (sel < 58) return FUNC_FIND;
    if (sel < 72) return FUNC_READ;
    if (sel < 86) return FUNC_SET;
    if (sel < 89) return FUNC_CLEAR;
    if (sel < 97) return FUNC_INIT;
    return FUNC_UNUSED;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // edge labels, every operation but init, and each refusal path but the full-table add
  task automatic test_directed_ops;
    send_beat(make_req(FUNC_ADD,    LABEL_MIN, 8'd0));
    send_beat(make_req(FUNC_ADD,    LABEL_MAX, 8'd0));
    send_beat(make_req(FUNC_ADD,    -1,        8'd0));
    send_beat(make_req(FUNC_ADD,    LABEL_MAX, 8'd0));   // duplicate add
    send_beat(make_req(FUNC_FIND,   -1,        8'd0));
    send_beat(make_req(FUNC_FIND,   12345,     8'd0));   // absent
    send_beat(make_req(FUNC_READ,   0,         8'd0));
    send_beat(make_req(FUNC_READ,   0,         8'd3));   // index == count
    send_beat(make_req(FUNC_READ,   0,         8'd255));
    send_beat(make_req(FUNC_SET,    7,         8'd1));
    send_beat(make_req(FUNC_SET,    LABEL_MIN, 8'd0));   // same label at target
    send_beat(make_req(FUNC_SET,    99,        8'd200)); // out of range
    send_beat(make_req(FUNC_SET,    7,         8'd2));   // present elsewhere
    send_beat(make_req(FUNC_REMOVE, LABEL_MIN, 8'd0));   // head removal, shift
    send_beat(make_req(FUNC_READ,   0,         8'd0));
    send_beat(make_req(FUNC_REMOVE, 4242,      8'd0));   // absent
    send_beat(make_req(FUNC_UNUSED, LABEL_MAX, 8'd255));
    send_beat(make_req(FUNC_CLEAR,  0,         8'd0));
    send_beat(make_req(FUNC_READ,   0,         8'd0));   // empty table
    drain_table();
  endtask

  // init count above the table size, full-table add, then an empty init
  task automatic test_init_extremes;
    write_init_count(5'd31);
    send_beat(make_req(FUNC_INIT,   0,  8'd0));
    send_beat(make_req(FUNC_ADD,    99, 8'd0));          // table full
    send_beat(make_req(FUNC_READ,   0,  8'd15));
    send_beat(make_req(FUNC_FIND,   15, 8'd0));
    drain_table();
    write_init_count(5'd0);
    send_beat(make_req(FUNC_INIT,   0,  8'd0));
    send_beat(make_req(FUNC_REMOVE, 0,  8'd0));          // nothing left
    drain_table();
  endtask

  task automatic test_random_mix(input logic [4:0] init_n, input int n_items);
    write_init_count(init_n);
    repeat (n_items)
      send_beat(make_req(pick_func(), pick_label(), pick_index()));
    drain_table();
  endtask

  // back-to-back beats, ready held high
  task automatic test_streaming(input int n_items);
    req_gaps = 1'b0;
    rsp_gaps = 1'b0;
    test_random_mix(5'($urandom_range(0, 31)), n_items);
  endtask

  initial begin
    rst               = 1'b1;
    req_valid         = 1'b0;
    req               = '0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    shadow_fill       = 0;
    shadow_init_count = '0;
    errors            = 0;
    beats_sent        = 0;
    beats_checked     = 0;
    full_refusals     = 0;
    cfg_writes        = 0;
    req_gaps          = 1'b1;
    rsp_gaps          = 1'b1;
    foreach (shadow_labels[i]) shadow_labels[i] = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed_ops();
    test_init_extremes();
    test_random_mix(5'd16, 250);
    test_random_mix(5'd31, 250);
    test_random_mix(5'd0,  250);
    test_random_mix(5'd1,  250);
    test_random_mix(5'd15, 250);
    test_random_mix(5'($urandom_range(2, 14)), 250);
    test_streaming(250);

    foreach (expected_rsp[i]) begin
      $error("missing response: ok=%0d idx=%0d label=%0d count=%0d", expected_rsp[i].ok,
             expected_rsp[i].found_index, expected_rsp[i].label_out, expected_rsp[i].count);
      errors++;
    end

    $display("covered %0d request beats over %0d init_count settings, %0d responses checked",
             beats_sent, cfg_writes, beats_checked);
    $display("adds refused on a full table: %0d, mismatches: %0d", full_refusals, errors);
    if (errors == 0) begin
      $display("unique_label_table regression: pass");
    end else begin
      $display("unique_label_table regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/ult_pkg.sv
rtl/ult_cell.sv
rtl/unique_label_table.sv
sim/unique_label_table_tb.sv
